// File: rtl/core/bmp_header_validator_defines.svh
// assertion macros shared by the bmp header validator rtl
`ifndef BMP_HEADER_VALIDATOR_DEFINES_SVH
`define BMP_HEADER_VALIDATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BHV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BHV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bhv_pkg.sv
// package: item types, status codes and header field layout
`default_nettype none

package bhv_pkg;

  localparam logic [5:0]  HeaderBytes  = 6'd54;
  localparam logic [5:0]  LastPos      = 6'd53;
  localparam logic [15:0] BmpSignature = 16'h4D42;
  localparam logic [31:0] InfoVersion  = 32'd40;
  localparam logic [31:0] MaxPalette   = 32'd256;
  localparam logic [15:0] DepthTrue    = 16'd24;
  localparam logic [15:0] DepthIndexed = 16'd8;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SIGNATURE   = 4'd1,
    ST_SIZE        = 4'd2,
    ST_RESERVED    = 4'd3,
    ST_VERSION     = 4'd4,
    ST_WIDTH       = 4'd5,
    ST_HEIGHT      = 4'd6,
    ST_PLANES      = 4'd7,
    ST_BPP         = 4'd8,
    ST_COMPRESSION = 4'd9,
    ST_PIXEL_SIZE  = 4'd10,
    ST_PAL_MISSING = 4'd11,
    ST_PAL_OVER    = 4'd12,
    ST_PAL_TRUE    = 4'd13
  } bhv_status_e;

  typedef enum logic [4:0] {
    FLD_SIGNATURE,
    FLD_FILE_SIZE,
    FLD_RESERVED1,
    FLD_RESERVED2,
    FLD_OFFSET,
    FLD_VERSION,
    FLD_WIDTH,
    FLD_HEIGHT,
    FLD_PLANES,
    FLD_DEPTH,
    FLD_COMPRESSION,
    FLD_PIXEL_SIZE,
    FLD_HRES,
    FLD_VRES,
    FLD_COLORS,
    FLD_IMPORTANT,
    FLD_NONE
  } bhv_field_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        start_of_header;
    logic [31:0] file_length;
  } bhv_in_t;

  typedef struct packed {
    logic [3:0]         status_code;
    logic [30:0]        image_width;
    logic signed [31:0] image_height;
    logic [15:0]        pixel_depth;
    logic [31:0]        palette_colors;
    logic [31:0]        pixel_offset;
  } bhv_out_t;

  typedef struct packed {
    logic     valid;
    bhv_out_t item;
  } bhv_res_t;

  // field that ends on a given header byte
  function automatic bhv_field_e field_of_pos(input logic [5:0] pos);
    bhv_field_e fld;
    case (pos)
      6'd1:    fld = FLD_SIGNATURE;
      6'd5:    fld = FLD_FILE_SIZE;
      6'd7:    fld = FLD_RESERVED1;
      6'd9:    fld = FLD_RESERVED2;
      6'd13:   fld = FLD_OFFSET;
      6'd17:   fld = FLD_VERSION;
      6'd21:   fld = FLD_WIDTH;
      6'd25:   fld = FLD_HEIGHT;
      6'd27:   fld = FLD_PLANES;
      6'd29:   fld = FLD_DEPTH;
      6'd33:   fld = FLD_COMPRESSION;
      6'd37:   fld = FLD_PIXEL_SIZE;
      6'd41:   fld = FLD_HRES;
      6'd45:   fld = FLD_VRES;
      6'd49:   fld = FLD_COLORS;
      6'd53:   fld = FLD_IMPORTANT;
      default: fld = FLD_NONE;
    endcase
    return fld;
  endfunction

  function automatic logic field_is_short(input bhv_field_e fld);
    return (fld inside {FLD_SIGNATURE, FLD_RESERVED1, FLD_RESERVED2, FLD_PLANES, FLD_DEPTH});
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bhv_checker.sv
// field assembly, header state and per-field checks
`default_nettype none
`include "bmp_header_validator_defines.svh"

module bhv_checker import bhv_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    take_i,
  input  wire bhv_in_t item_i,
  output bhv_res_t     res_o
);

  logic [5:0]  pos_q, pos_d;
  logic [31:0] shf_q, shf_d;
  logic [31:0] sampled_q, sampled_d;
  logic [31:0] size_q, size_d;
  logic [31:0] offset_q, offset_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [15:0] depth_q, depth_d;
  logic [31:0] colors_q, colors_d;
  logic        finished_q, finished_d;

  logic        start;
  logic        active;
  logic [5:0]  pos_cur;
  logic [31:0] shf_cur;
  logic [31:0] val;
  logic        indexed;
  logic        code_valid;
  bhv_status_e code;
  bhv_field_e  fld;

  always_comb begin
    start   = item_i.start_of_header;
    active  = start || !finished_q;
    pos_cur = start ? 6'd0 : pos_q;
    shf_cur = {item_i.data_byte, (start ? 24'h0 : shf_q[31:8])};
    fld     = field_of_pos(pos_cur);
    val     = field_is_short(fld) ? {16'h0, shf_cur[31:16]} : shf_cur;

    sampled_d = start ? item_i.file_length : sampled_q;
    size_d    = start ? 32'h0 : size_q;
    offset_d  = start ? 32'h0 : offset_q;
    width_d   = start ? 32'h0 : width_q;
    height_d  = start ? 32'h0 : height_q;
    depth_d   = start ? 16'h0 : depth_q;
    colors_d  = start ? 32'h0 : colors_q;
    shf_d     = shf_cur;
    pos_d     = pos_cur + 6'd1;
    indexed   = (depth_d == DepthIndexed);

    code_valid = 1'b0;
    code       = ST_OK;
    case (fld)
      FLD_SIGNATURE: begin
        code_valid = (val[15:0] != BmpSignature);
        code       = ST_SIGNATURE;
      end
      FLD_FILE_SIZE: begin
        size_d     = val;
        code_valid = (val != sampled_d);
        code       = ST_SIZE;
      end
      FLD_RESERVED1, FLD_RESERVED2: begin
        code_valid = (val != 32'h0);
        code       = ST_RESERVED;
      end
      FLD_OFFSET: offset_d = val;
      FLD_VERSION: begin
        code_valid = (val != InfoVersion);
        code       = ST_VERSION;
      end
      FLD_WIDTH: begin
        width_d    = val;
        code_valid = val[31] || (val == 32'h0);
        code       = ST_WIDTH;
      end
      FLD_HEIGHT: begin
        height_d   = val;
        code_valid = (val == 32'h0);
        code       = ST_HEIGHT;
      end
      FLD_PLANES: begin
        code_valid = (val != 32'd1);
        code       = ST_PLANES;
      end
      FLD_DEPTH: begin
        depth_d    = val[15:0];
        code_valid = (val[15:0] != DepthIndexed) && (val[15:0] != DepthTrue);
        code       = ST_BPP;
      end
      FLD_COMPRESSION: begin
        code_valid = (val != 32'h0);
        code       = ST_COMPRESSION;
      end
      FLD_PIXEL_SIZE: begin
        code_valid = (val != 32'h0) && (val != (size_d - offset_d));
        code       = ST_PIXEL_SIZE;
      end
      FLD_COLORS: begin
        colors_d = val;
        if ((val == 32'h0) && indexed) begin
          code_valid = 1'b1;
          code       = ST_PAL_MISSING;
        end else if ((val > MaxPalette) && indexed) begin
          code_valid = 1'b1;
          code       = ST_PAL_OVER;
        end else if ((val != 32'h0) && (depth_d == DepthTrue)) begin
          code_valid = 1'b1;
          code       = ST_PAL_TRUE;
        end
      end
      FLD_IMPORTANT: begin
        code_valid = 1'b1;
        code       = ((val > MaxPalette) && indexed) ? ST_PAL_OVER : ST_OK;
      end
      default: ;
    endcase

    // all fields passed once the last header byte is in
    if (!code_valid && (pos_d >= HeaderBytes)) begin
      code_valid = 1'b1;
      code       = ST_OK;
    end

    finished_d = code_valid;

    res_o.valid                = active && code_valid;
    res_o.item.status_code     = code;
    res_o.item.image_width     = width_d[30:0];
    res_o.item.image_height    = height_d;
    res_o.item.pixel_depth     = depth_d;
    res_o.item.palette_colors  = colors_d;
    res_o.item.pixel_offset    = offset_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      shf_q      <= '0;
      sampled_q  <= '0;
      size_q     <= '0;
      offset_q   <= '0;
      width_q    <= '0;
      height_q   <= '0;
      depth_q    <= '0;
      colors_q   <= '0;
      finished_q <= 1'b1;
    end else if (take_i && active) begin
      pos_q      <= pos_d;
      shf_q      <= shf_d;
      sampled_q  <= sampled_d;
      size_q     <= size_d;
      offset_q   <= offset_d;
      width_q    <= width_d;
      height_q   <= height_d;
      depth_q    <= depth_d;
      colors_q   <= colors_d;
      finished_q <= finished_d;
    end
  end

  `BHV_ASSERT_NOW(a_idle_silent, !start && finished_q, !res_o.valid, "result while idle")
  `BHV_ASSERT_NOW(a_ok_at_end, res_o.valid && (code == ST_OK), pos_cur == LastPos, "ok too early")
  `BHV_ASSERT_NEXT(a_result_ends, take_i && res_o.valid, finished_q, "parse not closed after result")

endmodule

`default_nettype wire

// File: rtl/core/bhv_result_reg.sv
// output register holding one result item until taken
`default_nettype none
`include "bmp_header_validator_defines.svh"

module bhv_result_reg import bhv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire bhv_out_t item_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output bhv_out_t      out_item_o
);

  logic     valid_q, valid_d;
  bhv_out_t item_q;
  logic     depth_ok;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  assign depth_ok = (item_q.pixel_depth == DepthIndexed) || (item_q.pixel_depth == DepthTrue);

  `BHV_ASSERT_NOW(a_no_overwrite, load_i, free_o, "result overwritten before taken")
  `BHV_ASSERT_NOW(a_ok_depth, valid_q && (item_q.status_code == ST_OK), depth_ok, "ok with bad depth")

endmodule

`default_nettype wire

// File: rtl/core/bmp_header_validator.sv
// top level: input register, header checker and result register
//
// Takes the 54 bytes of a bmp file header and info header, one byte per
// item on the input channel, and reports one result item per file.
// Set start_of_header on the first byte of each file, together with the
// file's real length in file_length. A result carries the first failing
// status code, or ok after the last header byte, plus the fields captured
// so far. Bytes after a result, or after reset, are dropped until the next
// start; a new start in mid-header drops the old parse silently.
// out_valid_o rises once the byte causing the result has passed the input
// register and then the result register. Throughput: one byte per cycle
// while the result register is free; every check works on the assembled
// field, some against fields captured earlier, and is done between the
// input and result registers.
// Reset leaves the parser idle with no result pending. While the receiver
// stalls, the pending result holds and one more byte is buffered in the
// input register; after that in_ready_o drops.
`default_nettype none
`include "bmp_header_validator_defines.svh"

module bmp_header_validator import bhv_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire bhv_in_t  in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output bhv_out_t      out_item_o
);

  logic     in_valid_q, in_valid_d;
  bhv_in_t  in_item_q;
  logic     out_free;
  logic     advance;
  logic     in_fire;
  bhv_res_t res;

  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= in_item_i;
    end
  end

  bhv_checker u_checker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (advance),
    .item_i (in_item_q),
    .res_o  (res)
  );

  bhv_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res.valid),
    .item_i      (res.item),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  `BHV_ASSERT_NOW(a_empty_ready, !in_valid_q, in_ready_o, "empty input stage not ready")
  `BHV_ASSERT_NEXT(a_stall_hold, in_valid_q && !out_free, in_valid_q, "input item lost in stall")

endmodule

`default_nettype wire
